FILE: design/assert_macros.svh
// Assertion macros shared by the sampler RTL.
// Each macro expands to one labeled concurrent assertion on clk, held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/bis_pkg.sv
// Package for the bilinear image sampler: sizes, codes and the blend function.
// It depends on nothing and is used by the top level.
package bis_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int FRAC_BITS  = 8;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int IDX_W       = 20;
  localparam int DIM_W       = 11;
  localparam int COORD_W     = 18;
  localparam int PIX_W       = 8;
  localparam int SUM_W       = PIX_W + 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = DIM_W;

  localparam int DIV3_MUL    = 683;
  localparam int DIV3_SHIFT  = 11;
  localparam int DIV3_MUL_W  = 10;

  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = FIFO_PTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_MODE = 2'd2;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef logic [PIX_W-1:0]     pix_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  function automatic pix_t blend(pix_t a, pix_t b, frac_t f);
    logic [FRAC_BITS:0]             wa;
    logic [PIX_W+FRAC_BITS:0]       acc;
    wa  = (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(f);
    acc = (PIX_W+FRAC_BITS+1)'(a) * (PIX_W+FRAC_BITS+1)'(wa)
        + (PIX_W+FRAC_BITS+1)'(b) * (PIX_W+FRAC_BITS+1)'(f);
    return acc[FRAC_BITS +: PIX_W];
  endfunction

endpackage

FILE: design/bilinear_image_sampler_core.sv
// Top level of the bilinear image sampler: load pipeline, neighbor reads, blends, result queue.
// It depends on bis_pkg, bis_ram and assert_macros.svh.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     mode, pixel_index, red, green, blue, x, y
//   out_     output     out_valid / out_ready   sample_value
//   cfg_     input      cfg_we                  cfg_index, cfg_data
//
// One item is accepted per cycle while in_ready is high; a sample's blended result is queued.
// The four neighbors are read in the same cycle from two store copies, one per row, two ports each.
// Loads and reads issue from the same stage in order, so a sample sees every earlier load.
// Results wait in an eight-entry queue; in_ready drops only when eight samples are unclaimed.
// Reset is synchronous; the store is not cleared and is undefined until written.
`include "assert_macros.svh"

module bilinear_image_sampler_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic [bis_pkg::IDX_W-1:0]         in_pixel_index,
  input  logic [bis_pkg::PIX_W-1:0]         in_red,
  input  logic [bis_pkg::PIX_W-1:0]         in_green,
  input  logic [bis_pkg::PIX_W-1:0]         in_blue,
  input  logic [bis_pkg::COORD_W-1:0]       in_sample_x,
  input  logic [bis_pkg::COORD_W-1:0]       in_sample_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bis_pkg::PIX_W-1:0]         out_sample_value,
  input  logic                              cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bis_pkg::*;

  logic [DIM_W-1:0]      width_r;
  logic [DIM_W-1:0]      height_r;
  logic                  avg_r;
  logic [DIM_W-1:0]      cfg_dim;
  logic [DIM_W-1:0]      cfg_w_clamped;
  logic [DIM_W-1:0]      cfg_h_clamped;

  logic                  in_acc;
  logic                  smp_acc;
  logic                  out_acc;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;

  logic [DIM_W-1:0]      wm1;
  logic [DIM_W-1:0]      hm1;
  logic [COORD_W-1:0]    xmax;
  logic [COORD_W-1:0]    ymax;
  logic [COORD_W-1:0]    sx_c;
  logic [COORD_W-1:0]    sy_c;

  logic                  s1_v_r;
  logic                  s1_smp_r;
  logic [COL_W-1:0]      s1_xf_r;
  logic [ROW_W-1:0]      s1_yf_r;
  frac_t                 s1_fx_r;
  frac_t                 s1_fy_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic [SUM_W-1:0]      s1_val_r;
  logic                  s1_avg_r;

  logic [ROW_W-1:0]      s1_yc;
  logic [SUM_W+DIV3_MUL_W-1:0] s1_div_prod;

  logic                  s2_v_r;
  logic                  s2_smp_r;
  addr_t                 s2_pf_r;
  addr_t                 s2_pc_r;
  logic [COL_W-1:0]      s2_xf_r;
  logic [COL_W-1:0]      s2_xc_r;
  frac_t                 s2_fx_r;
  frac_t                 s2_fy_r;
  logic [IDX_W-1:0]      s2_idx_r;
  pix_t                  s2_pix_r;

  logic                  ram_we;
  logic                  ram_re;
  addr_t                 a_ff;
  addr_t                 a_fc;
  addr_t                 a_cf;
  addr_t                 a_cc;
  pix_t                  v_ff;
  pix_t                  v_fc;
  pix_t                  v_cf;
  pix_t                  v_cc;

  logic                  s3_v_r;
  frac_t                 s3_fx_r;
  frac_t                 s3_fy_r;

  logic                  s4_v_r;
  pix_t                  s4_q1_r;
  pix_t                  s4_q2_r;
  frac_t                 s4_fy_r;

  pix_t                  fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0]      fifo_cnt_r;
  logic [CNT_W-1:0]      fifo_cnt_nxt;

  // Configuration: dimensions are held already clamped to their legal range.
  always_comb begin
    cfg_dim = cfg_data[DIM_W-1:0];
    if (cfg_dim == '0) begin
      cfg_w_clamped = DIM_W'(1);
      cfg_h_clamped = DIM_W'(1);
    end else begin
      cfg_w_clamped = (cfg_dim > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : cfg_dim;
      cfg_h_clamped = (cfg_dim > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_dim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_WIDTH);
      height_r <= DIM_W'(MAX_HEIGHT);
      avg_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_w_clamped;
        CFG_IMAGE_HEIGHT: height_r <= cfg_h_clamped;
        CFG_AVERAGE_MODE: avg_r    <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Credits: every accepted sample holds a place in the result queue until it is taken.
  assign in_ready = (cnt_r < CNT_W'(FIFO_DEPTH));
  assign in_acc   = in_valid & in_ready;
  assign smp_acc  = in_acc & (in_mode == MODE_SAMPLE);
  assign out_acc  = out_valid & out_ready;
  assign cnt_nxt  = cnt_r + CNT_W'(smp_acc) - CNT_W'(out_acc);

  // Stage 1: saturate the coordinates and split them into integer and fraction.
  always_comb begin
    wm1  = width_r - DIM_W'(1);
    hm1  = height_r - DIM_W'(1);
    xmax = {wm1[COL_W-1:0], {FRAC_BITS{1'b0}}};
    ymax = {hm1[ROW_W-1:0], {FRAC_BITS{1'b0}}};
    sx_c = (in_sample_x > xmax) ? xmax : in_sample_x;
    sy_c = (in_sample_y > ymax) ? ymax : in_sample_y;
  end

  // Stage 2: row base products and the divide by three of the load value.
  assign s1_yc       = s1_yf_r + ROW_W'(s1_fy_r != '0);
  assign s1_div_prod = s1_val_r * DIV3_MUL_W'(DIV3_MUL);

  // Store access: loads write and samples read from the same stage, in item order.
  assign ram_we = s2_v_r & ~s2_smp_r;
  assign ram_re = s2_v_r & s2_smp_r;
  assign a_ff   = s2_pf_r + ADDR_W'(s2_xf_r);
  assign a_fc   = s2_pf_r + ADDR_W'(s2_xc_r);
  assign a_cf   = s2_pc_r + ADDR_W'(s2_xf_r);
  assign a_cc   = s2_pc_r + ADDR_W'(s2_xc_r);

  bis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram_floor_row (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (s2_idx_r[ADDR_W-1:0]),
    .wdata   (s2_pix_r),
    .re      (ram_re),
    .raddr_a (a_ff),
    .raddr_b (a_fc),
    .rdata_a (v_ff),
    .rdata_b (v_fc)
  );

  bis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram_ceil_row (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (s2_idx_r[ADDR_W-1:0]),
    .wdata   (s2_pix_r),
    .re      (ram_re),
    .raddr_a (a_cf),
    .raddr_b (a_cc),
    .rdata_a (v_cf),
    .rdata_b (v_cc)
  );

  // Control registers of the pipeline and the result queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      s4_v_r     <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      cnt_r      <= cnt_nxt;
      s1_v_r     <= in_acc;
      s2_v_r     <= s1_v_r;
      s3_v_r     <= ram_re;
      s4_v_r     <= s3_v_r;
      fifo_cnt_r <= fifo_cnt_nxt;
      if (s4_v_r) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
    end
  end

  assign fifo_cnt_nxt = fifo_cnt_r + CNT_W'(s4_v_r) - CNT_W'(out_acc);

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_smp_r <= in_mode;
    s1_xf_r  <= sx_c[FRAC_BITS +: COL_W];
    s1_yf_r  <= sy_c[FRAC_BITS +: ROW_W];
    s1_fx_r  <= sx_c[FRAC_BITS-1:0];
    s1_fy_r  <= sy_c[FRAC_BITS-1:0];
    s1_idx_r <= in_pixel_index;
    s1_avg_r <= avg_r;
    s1_val_r <= avg_r ? (SUM_W'(in_red) + SUM_W'(in_green) + SUM_W'(in_blue))
                      : SUM_W'(in_red);

    s2_smp_r <= s1_smp_r;
    s2_pf_r  <= ADDR_W'(s1_yf_r) * ADDR_W'(width_r);
    s2_pc_r  <= ADDR_W'(s1_yc) * ADDR_W'(width_r);
    s2_xf_r  <= s1_xf_r;
    s2_xc_r  <= s1_xf_r + COL_W'(s1_fx_r != '0);
    s2_fx_r  <= s1_fx_r;
    s2_fy_r  <= s1_fy_r;
    s2_idx_r <= s1_idx_r;
    s2_pix_r <= s1_avg_r ? s1_div_prod[DIV3_SHIFT +: PIX_W] : s1_val_r[PIX_W-1:0];

    s3_fx_r  <= s2_fx_r;
    s3_fy_r  <= s2_fy_r;

    s4_q1_r  <= blend(v_ff, v_fc, s3_fx_r);
    s4_q2_r  <= blend(v_cf, v_cc, s3_fx_r);
    s4_fy_r  <= s3_fy_r;

    if (s4_v_r) begin
      fifo_mem_r[wr_ptr_r] <= blend(s4_q1_r, s4_q2_r, s4_fy_r);
    end
  end

  assign out_valid        = (fifo_cnt_r != '0);
  assign out_sample_value = fifo_mem_r[rd_ptr_r];

  `ASSERT_ALWAYS(a_credit_bound, cnt_r <= CNT_W'(FIFO_DEPTH), "credit count above queue depth")
  `ASSERT_ALWAYS(a_queue_within_credit, fifo_cnt_r <= cnt_r, "queue holds more than its credits")
  `ASSERT_IMPLIES(a_no_push_when_full, s4_v_r, fifo_cnt_r != CNT_W'(FIFO_DEPTH), "result pushed into full queue")
  `ASSERT_ALWAYS(a_one_store_access, !(ram_we && ram_re), "store written and read by one item")

endmodule

FILE: design/bis_ram.sv
// Generic synchronous RAM: one write port and two read ports with registered read data.
// It depends on nothing; the sampler uses two copies as its image store.
module bis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
